### rtl/smc_pkg.sv
// Shared types and constants for the subsequence match counter.
// Holds the action codes, controller states and the cell command/result structs.
// No dependencies.
package smc_pkg;

    localparam int SYM_W   = 5;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_WORD   = 2'd2,
        ACT_END    = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_SEARCH = 1'b1
    } state_t;

    // broadcast from the controller to every letter cell
    typedef struct packed {
        logic             clear;
        logic             append;
        logic             search;
        logic [SYM_W-1:0] symbol;
    } cell_cmd_t;

    // handed along the row of cells
    typedef struct packed {
        logic done;
        logic found;
    } cell_res_t;

endpackage

### rtl/smc_item_if.sv
// Input channel of the subsequence match counter: valid/ready plus one item.
// Depends on smc_pkg.
interface smc_item_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [smc_pkg::SYM_W-1:0] symbol;

    modport source (output valid, output action, output symbol, input ready);
    modport sink   (input valid, input action, input symbol, output ready);
endinterface

### rtl/smc_result_if.sv
// Output channel of the subsequence match counter: valid/ready plus one result.
// Depends on smc_pkg.
interface smc_result_if;
    logic                        valid;
    logic                        ready;
    logic                        matched;
    logic [smc_pkg::COUNT_W-1:0] match_count;

    modport source (output valid, output matched, output match_count, input ready);
    modport sink   (input valid, input matched, input match_count, output ready);
endinterface

### rtl/subsequence_match_counter_core.sv
// Subsequence match counter top level: controller plus a row of letter cells.
// Clear, append, end-of-word and skipped word letters need no search; a word
// letter that searches holds item.ready low until the search is done, with one probe
// of the letter's list memory per cycle. A result beat is valid the cycle after
// the end-of-word beat. Reset empties all lists and zeroes the count; list
// memories are not cleared, stale entries are never read.
module subsequence_match_counter_core #(
    parameter int TEXT_MAX = 1024,
    parameter int ALPHABET = 26
) (
    input  logic          clk,
    input  logic          rst_n,
    smc_item_if.sink      item,
    smc_result_if.source  result
);
    import smc_pkg::*;

    localparam int AW    = $clog2(TEXT_MAX);
    localparam int LEN_W = $clog2(TEXT_MAX + 1);

    state_t             state_reg,     state_next;
    logic [LEN_W-1:0]   text_len_reg,  text_len_next;
    logic [AW-1:0]      last_pos_reg,  last_pos_next;
    logic               last_none_reg, last_none_next;
    logic               still_reg,     still_next;
    logic [COUNT_W-1:0] total_reg,     total_next;
    logic               out_valid_reg, out_valid_next;
    logic               matched_reg,   matched_next;
    logic [COUNT_W-1:0] count_reg,     count_next;

    logic               accept;
    logic               sym_ok;
    logic               text_room;
    cell_cmd_t          cmd;

    cell_res_t          chain_res [ALPHABET+1];
    logic [AW-1:0]      chain_pos [ALPHABET+1];

    assign sym_ok    = (int'(item.symbol) < ALPHABET);
    assign text_room = (text_len_reg < LEN_W'(TEXT_MAX));
    assign accept    = item.valid && item.ready;

    assign chain_res[0] = '0;
    assign chain_pos[0] = '0;

    for (genvar g = 0; g < ALPHABET; g++)
    begin : g_cell
        smc_letter_cell #(
            .TEXT_MAX (TEXT_MAX),
            .CELL_ID  (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .text_pos  (text_len_reg[AW-1:0]),
            .last_pos  (last_pos_reg),
            .last_none (last_none_reg),
            .res_in    (chain_res[g]),
            .pos_in    (chain_pos[g]),
            .res_out   (chain_res[g+1]),
            .pos_out   (chain_pos[g+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.action == ACT_WORD && still_reg && sym_ok)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (chain_res[ALPHABET].done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        item.ready     = (state_reg == ST_IDLE) && (!out_valid_reg || result.ready);
        cmd            = '0;
        cmd.symbol     = item.symbol;
        text_len_next  = text_len_reg;
        last_pos_next  = last_pos_reg;
        last_none_next = last_none_reg;
        still_next     = still_reg;
        total_next     = total_reg;
        matched_next   = matched_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !result.ready;

        if (accept)
        begin
            case (item.action)
                ACT_CLEAR:
                begin
                    cmd.clear      = 1'b1;
                    text_len_next  = '0;
                    total_next     = '0;
                    last_none_next = 1'b1;
                    still_next     = 1'b1;
                end
                ACT_APPEND:
                begin
                    if (sym_ok && text_room)
                    begin
                        cmd.append    = 1'b1;
                        text_len_next = text_len_reg + LEN_W'(1);
                    end
                end
                ACT_WORD:
                begin
                    if (still_reg)
                    begin
                        if (sym_ok)
                        begin
                            cmd.search = 1'b1;
                        end
                        else
                        begin
                            still_next = 1'b0;
                        end
                    end
                end
                ACT_END:
                begin
                    if (still_reg && total_reg != COUNT_MAX)
                    begin
                        total_next = total_reg + COUNT_W'(1);
                    end
                    out_valid_next = 1'b1;
                    matched_next   = still_reg;
                    count_next     = (still_reg && total_reg != COUNT_MAX)
                                     ? total_reg + COUNT_W'(1) : total_reg;
                    last_none_next = 1'b1;
                    still_next     = 1'b1;
                end
                default:
                begin
                    cmd.clear = 1'b0;
                end
            endcase
        end

        if (state_reg == ST_SEARCH && chain_res[ALPHABET].done)
        begin
            if (chain_res[ALPHABET].found)
            begin
                last_pos_next  = chain_pos[ALPHABET];
                last_none_next = 1'b0;
            end
            else
            begin
                still_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            text_len_reg  <= '0;
            last_none_reg <= 1'b1;
            still_reg     <= 1'b1;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            text_len_reg  <= text_len_next;
            last_none_reg <= last_none_next;
            still_reg     <= still_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_pos_reg <= last_pos_next;
        matched_reg  <= matched_next;
        count_reg    <= count_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.matched     = matched_reg;
    assign result.match_count = count_reg;

    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain_res[ALPHABET].done |-> state_reg == ST_SEARCH)
        else $error("search result outside a search");

    a_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept && item.action == ACT_END))
        else $error("result beat without an end-of-word beat");

    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && matched_reg) |-> count_reg != '0)
        else $error("matched word not counted");

    a_text_bound: assert property (@(posedge clk) disable iff (!rst_n)
        text_len_reg <= LEN_W'(TEXT_MAX))
        else $error("text length beyond capacity");

endmodule

### rtl/smc_letter_cell.sv
// One letter cell: position list memory, list length and a binary search unit.
// Results are merged into the value handed on from the previous cell.
// Depends on smc_pkg.
module smc_letter_cell #(
    parameter int TEXT_MAX = 1024,
    parameter int CELL_ID  = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  smc_pkg::cell_cmd_t                  cmd,
    input  logic [$clog2(TEXT_MAX)-1:0]         text_pos,
    input  logic [$clog2(TEXT_MAX)-1:0]         last_pos,
    input  logic                                last_none,
    input  smc_pkg::cell_res_t                  res_in,
    input  logic [$clog2(TEXT_MAX)-1:0]         pos_in,
    output smc_pkg::cell_res_t                  res_out,
    output logic [$clog2(TEXT_MAX)-1:0]         pos_out
);
    import smc_pkg::*;

    localparam int AW    = $clog2(TEXT_MAX);
    localparam int LEN_W = $clog2(TEXT_MAX + 1);

    logic [AW-1:0]    mem [TEXT_MAX];
    logic [AW-1:0]    rdata_reg;

    logic [LEN_W-1:0] len_reg,   len_next;
    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic             found_reg, found_next;
    logic             hit_reg,   hit_next;
    logic [LEN_W-1:0] lo_reg,    lo_next;
    logic [LEN_W-1:0] hi_reg,    hi_next;
    logic [AW-1:0]    mid_reg,   mid_next;
    logic [AW-1:0]    hival_reg, hival_next;
    logic [AW-1:0]    pos_reg,   pos_next;

    logic             mine;
    logic             gt;
    logic [LEN_W-1:0] lo_step, hi_step, span, mid_full;
    logic             more;
    logic [AW-1:0]    rd_addr;

    assign mine = (int'(cmd.symbol) == CELL_ID);

    // one search step per cycle: the registered read is compared and the next
    // probe address goes straight back to the memory
    always_comb
    begin
        gt       = last_none || (rdata_reg > last_pos);
        lo_step  = gt ? lo_reg : (LEN_W'(mid_reg) + LEN_W'(1));
        hi_step  = gt ? LEN_W'(mid_reg) : hi_reg;
        span     = hi_step - lo_step;
        mid_full = lo_step + (span >> 1);
        more     = (lo_step < hi_step);
        rd_addr  = busy_reg ? mid_full[AW-1:0] : AW'(len_reg >> 1);
    end

    always_comb
    begin
        len_next   = len_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        hit_next   = hit_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        hival_next = hival_reg;
        pos_next   = pos_reg;

        if (cmd.clear)
        begin
            len_next = '0;
        end
        else if (cmd.append && mine)
        begin
            len_next = len_reg + LEN_W'(1);
        end

        if (busy_reg)
        begin
            lo_next  = lo_step;
            hi_next  = hi_step;
            mid_next = mid_full[AW-1:0];
            if (gt)
            begin
                hit_next   = 1'b1;
                hival_next = rdata_reg;
            end
            if (!more)
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                found_next = hit_reg || gt;
                pos_next   = gt ? rdata_reg : hival_reg;
            end
        end
        else if (cmd.search && mine)
        begin
            if (len_reg == '0)
            begin
                done_next  = 1'b1;
                found_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
                hit_next  = 1'b0;
                lo_next   = '0;
                hi_next   = len_reg;
                mid_next  = rd_addr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        hival_reg <= hival_next;
        pos_reg   <= pos_next;
    end

    // list never outgrows the text, so the length is a valid write address
    always_ff @(posedge clk)
    begin
        if (cmd.append && mine)
        begin
            mem[len_reg[AW-1:0]] <= text_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
    end

    assign res_out.done  = res_in.done  || done_reg;
    assign res_out.found = res_in.found || (done_reg && found_reg);
    assign pos_out       = pos_in | ((done_reg && found_reg) ? pos_reg : '0);

endmodule
